/* rtl/core/byte_machine_instruction_executor_top_macros.svh */
`ifndef BYTE_MACHINE_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define BYTE_MACHINE_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH

// same-cycle implication
`define BMIE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bmie_pkg.sv */
package bmie_pkg;

	localparam int NUM_REGISTERS = 16;
	localparam int MEM_DEPTH     = 256;
	localparam int DATA_W        = 8;
	localparam int REG_AW        = $clog2(NUM_REGISTERS);
	localparam int MEM_AW        = $clog2(MEM_DEPTH);

	localparam int IQ_DEPTH = 2;
	localparam int IQ_PW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

	localparam logic [3:0] FUNC_LOAD  = 4'h1;
	localparam logic [3:0] FUNC_IMM   = 4'h2;
	localparam logic [3:0] FUNC_STORE = 4'h3;
	localparam logic [3:0] FUNC_MOVE  = 4'h4;
	localparam logic [3:0] FUNC_ADD   = 4'h5;
	localparam logic [3:0] FUNC_JUMP  = 4'hB;
	localparam logic [3:0] FUNC_HALT  = 4'hC;

	localparam logic [REG_AW-1:0] REG_ZERO   = '0;
	localparam logic [DATA_W-1:0] PRINT_ADDR = '0;

	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [3:0] {
		CLS_NOP,
		CLS_LOAD,
		CLS_IMM,
		CLS_STORE,
		CLS_PRINT,
		CLS_MOVE,
		CLS_ADD,
		CLS_JUMP,
		CLS_HALT
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [REG_AW-1:0] wa;
		logic [REG_AW-1:0] ra_a;
		logic [REG_AW-1:0] ra_b;
		data_t             xy;
	} ins_t;

	typedef struct packed {
		logic valid;
		ins_t ins;
	} iq_head_t;

	typedef struct packed {
		data_t next_pc;
		logic  print_valid;
		data_t print_value;
		logic  halted;
	} res_t;

	typedef struct packed {
		logic push;
		res_t res;
	} res_push_t;

endpackage

/* rtl/core/byte_machine_instruction_executor_top.sv */
// Byte machine instruction executor: sixteen 8-bit registers, 256-byte data memory.
// Request side is a queue write port: an instruction (func, reg_index,
// operand_byte) is taken at a clock edge with push high and full low.
// Result side is a queue read port: while empty is low the oldest result
// (next_pc, print_valid, print_value, halted) is on the ports; it is taken
// at an edge with pop high and empty low. One result per request, in order.
// Path: a request goes into the decode queue, is read with its operands into
// the execute register, then executes into the result queue.
// Throughput: one request per cycle while the result queue has room; the register
// file and data memory each give a registered read ahead of execute, with bypass
// from the instruction executing, so dependent requests may follow back to back.
// Stalls: if pop stays low the two-entry result queue fills, execute holds,
// then the two-entry decode queue fills and full rises; nothing is lost.
// Reset (arst_n low) clears pc, halt, queues and the valid bits that make
// every register and memory byte read as zero until first written; no
// clearing pass, requests are taken from the first cycle after reset.
// After a halt, later requests still give one result each, with no effect.
`include "byte_machine_instruction_executor_top_macros.svh"

module byte_machine_instruction_executor_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [3:0] func,
	input  logic [3:0] reg_index,
	input  logic [7:0] operand_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] next_pc,
	output logic       print_valid,
	output logic [7:0] print_value,
	output logic       halted
);

	bmie_pkg::iq_head_t  iq_head;
	logic                iq_pop;
	logic                oq_full;
	bmie_pkg::res_push_t res_push;
	bmie_pkg::res_t      head;

	bmie_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.reg_index    (reg_index),
		.operand_byte (operand_byte),
		.iq_pop       (iq_pop),
		.iq_head      (iq_head)
	);

	bmie_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.iq_head  (iq_head),
		.iq_pop   (iq_pop),
		.oq_full  (oq_full),
		.res_push (res_push)
	);

	bmie_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.oq_full  (oq_full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign next_pc     = head.next_pc;
	assign print_valid = head.print_valid;
	assign print_value = head.print_value;
	assign halted      = head.halted;

	`BMIE_ASSERT_NEXT(a_accept_fills_iq, push && !full, iq_head.valid, "accepted request not queued")
	`BMIE_ASSERT_NOW(a_no_push_when_full, res_push.push, !oq_full, "result pushed into full queue")
	`BMIE_ASSERT_NEXT(a_halt_sticky, pop && !empty && halted, empty || halted, "halt not sticky")

endmodule

/* rtl/core/bmie_front.sv */
module bmie_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         func,
	input  logic [3:0]         reg_index,
	input  logic [7:0]         operand_byte,
	input  logic               iq_pop,
	output bmie_pkg::iq_head_t iq_head
);

	bmie_pkg::ins_t                 dec;
	bmie_pkg::ins_t                 mem_q [bmie_pkg::IQ_DEPTH];
	logic [bmie_pkg::IQ_PW-1:0]     wp_q;
	logic [bmie_pkg::IQ_PW-1:0]     rp_q;
	logic [bmie_pkg::IQ_CW-1:0]     cnt_q;
	logic                           wr;
	logic                           rd;

	// classify the request
	always_comb begin
		dec      = '0;
		dec.cls  = bmie_pkg::CLS_NOP;
		dec.xy   = operand_byte;
		case (func)
			bmie_pkg::FUNC_LOAD: begin
				dec.cls = bmie_pkg::CLS_LOAD;
				dec.wa  = reg_index;
			end
			bmie_pkg::FUNC_IMM: begin
				dec.cls = bmie_pkg::CLS_IMM;
				dec.wa  = reg_index;
			end
			bmie_pkg::FUNC_STORE: begin
				dec.cls  = (operand_byte == bmie_pkg::PRINT_ADDR) ?
					bmie_pkg::CLS_PRINT : bmie_pkg::CLS_STORE;
				dec.ra_a = reg_index;
			end
			bmie_pkg::FUNC_MOVE: begin
				dec.cls  = bmie_pkg::CLS_MOVE;
				dec.ra_a = operand_byte[7:4];
				dec.wa   = operand_byte[3:0];
			end
			bmie_pkg::FUNC_ADD: begin
				dec.cls  = bmie_pkg::CLS_ADD;
				dec.ra_a = operand_byte[7:4];
				dec.ra_b = operand_byte[3:0];
				dec.wa   = reg_index;
			end
			bmie_pkg::FUNC_JUMP: begin
				dec.cls  = bmie_pkg::CLS_JUMP;
				dec.ra_a = reg_index;
				dec.ra_b = bmie_pkg::REG_ZERO;
			end
			bmie_pkg::FUNC_HALT: begin
				dec.cls = bmie_pkg::CLS_HALT;
			end
			default: begin
				dec.cls = bmie_pkg::CLS_NOP;
			end
		endcase
	end

	assign full          = (cnt_q == bmie_pkg::IQ_CW'(bmie_pkg::IQ_DEPTH));
	assign wr            = push && !full;
	assign rd            = iq_pop && (cnt_q != '0);
	assign iq_head.valid = (cnt_q != '0);
	assign iq_head.ins   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bmie_back.sv */
module bmie_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bmie_pkg::iq_head_t  iq_head,
	output logic                iq_pop,
	input  logic                oq_full,
	output bmie_pkg::res_push_t res_push
);

	bmie_pkg::data_t                  rf_q [bmie_pkg::NUM_REGISTERS];
	logic [bmie_pkg::NUM_REGISTERS-1:0] rf_vld_q;
	bmie_pkg::data_t                  dm_q [bmie_pkg::MEM_DEPTH];
	logic [bmie_pkg::MEM_DEPTH-1:0]   dm_vld_q;

	logic                             v_s1;
	bmie_pkg::ins_t                   ins_s1;
	bmie_pkg::data_t                  rda_s1;
	bmie_pkg::data_t                  rdb_s1;
	bmie_pkg::data_t                  md_s1;

	bmie_pkg::data_t                  pc_q;
	logic                             halt_q;

	logic                             adv;
	logic                             commit;
	logic                             live;
	logic                             rf_we;
	logic [bmie_pkg::REG_AW-1:0]      rf_wa;
	bmie_pkg::data_t                  rf_wd;
	logic                             dm_we;
	logic [bmie_pkg::MEM_AW-1:0]      dm_wa;
	logic [bmie_pkg::MEM_AW-1:0]      dm_ra;
	bmie_pkg::data_t                  pc_nx;
	logic                             halt_nx;

	assign commit = v_s1 && !oq_full;
	assign adv    = iq_head.valid && (!v_s1 || commit);
	assign iq_pop = adv;
	assign live   = commit && !halt_q;
	assign dm_ra  = iq_head.ins.xy[bmie_pkg::MEM_AW-1:0];

	always_comb begin
		rf_we = 1'b0;
		dm_we = 1'b0;
		rf_wa = ins_s1.wa;
		dm_wa = ins_s1.xy[bmie_pkg::MEM_AW-1:0];
		rf_wd = rda_s1;
		case (ins_s1.cls)
			bmie_pkg::CLS_LOAD: begin
				rf_we = live;
				rf_wd = md_s1;
			end
			bmie_pkg::CLS_IMM: begin
				rf_we = live;
				rf_wd = ins_s1.xy;
			end
			bmie_pkg::CLS_MOVE: begin
				rf_we = live;
			end
			bmie_pkg::CLS_ADD: begin
				rf_we = live;
				rf_wd = rda_s1 + rdb_s1;
			end
			bmie_pkg::CLS_STORE: begin
				dm_we = live;
			end
			default: begin
				rf_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (halt_q) begin
			pc_nx = pc_q;
		end else if (ins_s1.cls == bmie_pkg::CLS_JUMP && rda_s1 == rdb_s1) begin
			pc_nx = ins_s1.xy - bmie_pkg::DATA_W'(1);
		end else begin
			pc_nx = pc_q + bmie_pkg::DATA_W'(1);
		end
		halt_nx                      = halt_q || (ins_s1.cls == bmie_pkg::CLS_HALT);
		res_push.push                = commit;
		res_push.res.next_pc         = pc_nx;
		res_push.res.print_valid     = !halt_q && (ins_s1.cls == bmie_pkg::CLS_PRINT);
		res_push.res.print_value     = res_push.res.print_valid ? rda_s1 : '0;
		res_push.res.halted          = halt_nx;
	end

	// storage
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
		if (dm_we) begin
			dm_q[dm_wa] <= rda_s1;
		end
	end

	// operand reads, with bypass from the committing request
	always_ff @(posedge clk) begin
		if (adv) begin
			ins_s1 <= iq_head.ins;
			if (rf_we && rf_wa == iq_head.ins.ra_a) begin
				rda_s1 <= rf_wd;
			end else begin
				rda_s1 <= rf_vld_q[iq_head.ins.ra_a] ? rf_q[iq_head.ins.ra_a] : '0;
			end
			if (rf_we && rf_wa == iq_head.ins.ra_b) begin
				rdb_s1 <= rf_wd;
			end else begin
				rdb_s1 <= rf_vld_q[iq_head.ins.ra_b] ? rf_q[iq_head.ins.ra_b] : '0;
			end
			if (dm_we && dm_wa == dm_ra) begin
				md_s1 <= rda_s1;
			end else begin
				md_s1 <= dm_vld_q[dm_ra] ? dm_q[dm_ra] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			pc_q     <= '0;
			halt_q   <= 1'b0;
			rf_vld_q <= '0;
			dm_vld_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= 1'b1;
			end else if (commit) begin
				v_s1 <= 1'b0;
			end
			if (commit) begin
				pc_q   <= pc_nx;
				halt_q <= halt_nx;
			end
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
			end
			if (dm_we) begin
				dm_vld_q[dm_wa] <= 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bmie_res_queue.sv */
module bmie_res_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  bmie_pkg::res_push_t res_push,
	output logic                oq_full,
	input  logic                pop,
	output logic                empty,
	output bmie_pkg::res_t      head
);

	bmie_pkg::res_t               mem_q [bmie_pkg::IQ_DEPTH];
	logic [bmie_pkg::IQ_PW-1:0]   wp_q;
	logic [bmie_pkg::IQ_PW-1:0]   rp_q;
	logic [bmie_pkg::IQ_CW-1:0]   cnt_q;
	logic                         wr;
	logic                         rd;

	assign oq_full = (cnt_q == bmie_pkg::IQ_CW'(bmie_pkg::IQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr      = res_push.push && !oq_full;
	assign rd      = pop && !empty;
	assign head    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= res_push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
